[design/assert_macros.svh]
// Assertion macros used by the allocator's top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define PBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/pba_pkg.sv]
// Shared types and constants of the paged bump allocator.
package pba_pkg;

  // Field widths of the item streams.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned IDXIN_W  = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned GPAGE_W  = 3;
  localparam int unsigned OFF_W    = 13;
  localparam int unsigned TOTAL_W  = 16;
  localparam int unsigned CNT_W    = 16;

  // Request codes.
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic update;
  } pba_cmd_t;

endpackage

[design/pba_ctrl.sv]
// Controller state machine of the paged bump allocator.
module pba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output pba_pkg::pba_cmd_t cmd_o
);
  import pba_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State and result-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands. The update waits until the output register is free.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        state_d    = S_UPDATE;
      end
      S_UPDATE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.update = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[design/pba_dp.sv]
// Datapath of the paged bump allocator: page tables, page search and result register.
module pba_dp #(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned PAGE_COUNT = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pba_pkg::pba_cmd_t              cmd_i,
  input  logic [pba_pkg::OP_W-1:0]       op_i,
  input  logic [pba_pkg::SIZE_W-1:0]     size_i,
  input  logic [pba_pkg::IDXIN_W-1:0]    idx_i,
  output logic [pba_pkg::STATUS_W-1:0]   status_o,
  output logic [pba_pkg::GPAGE_W-1:0]    gpage_o,
  output logic [pba_pkg::OFF_W-1:0]      goff_o,
  output logic                           released_o,
  output logic [pba_pkg::TOTAL_W-1:0]    total_o
);
  import pba_pkg::*;

  localparam int unsigned FILL_W = $clog2(PAGE_BYTES + 1);
  localparam int unsigned CMP_W  = (FILL_W > SIZE_W) ? FILL_W : SIZE_W;
  localparam int unsigned IDX_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned IDXX_W = (IDX_W > IDXIN_W) ? IDX_W : IDXIN_W;
  localparam int unsigned PICK_W = (IDX_W > GPAGE_W) ? IDX_W : GPAGE_W;
  localparam logic [CMP_W-1:0]   PAGE_LIM = CMP_W'(PAGE_BYTES);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX = '1;

  // Request registers.
  op_e                op_q;
  logic [SIZE_W-1:0]  size_q;
  logic [IDXIN_W-1:0] idx_q;

  // Page tables and running total.
  logic [PAGE_COUNT-1:0] in_use_q;
  logic [FILL_W-1:0]     fill_q [PAGE_COUNT];
  logic [CNT_W-1:0]      cnt_q  [PAGE_COUNT];
  logic [TOTAL_W-1:0]    total_q;

  // Search results.
  logic [IDX_W-1:0] pick_q, pick_d;
  logic             found_q, found_d;
  logic             new_q, new_d;

  logic [CMP_W-1:0]      size_ext;
  logic [PAGE_COUNT-1:0] fit;
  logic [PAGE_COUNT-1:0] sel_free;
  logic [IDXX_W-1:0]     idx_ext;
  logic                  idx_ok;
  logic                  free_ok;
  logic [CNT_W-1:0]      free_cnt;
  logic                  release_pg;
  logic [FILL_W-1:0]     pick_fill;
  logic [CNT_W-1:0]      pick_cnt;
  logic [FILL_W-1:0]     base_fill;
  logic [CMP_W-1:0]      base_ext;
  logic [FILL_W-1:0]     fill_nx;
  logic [CNT_W-1:0]      cnt_nx;
  logic [PICK_W-1:0]     pick_ext;
  logic [TOTAL_W:0]      total_sum;
  logic [TOTAL_W-1:0]    total_add;
  logic [TOTAL_W-1:0]    total_sub;
  logic [TOTAL_W-1:0]    total_nx;
  logic [STATUS_W-1:0]   status_nx;
  logic [GPAGE_W-1:0]    gpage_nx;
  logic [OFF_W-1:0]      goff_nx;
  logic                  released_nx;

  // Capture the request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(op_i);
      size_q <= size_i;
      idx_q  <= idx_i;
    end
  end

  assign size_ext = CMP_W'(size_q);

  // Per-page room check against the requested size.
  always_comb begin
    for (int p = 0; p < PAGE_COUNT; p++) begin
      fit[p] = in_use_q[p] && ((PAGE_LIM - CMP_W'(fill_q[p])) >= size_ext);
    end
  end

  // Lowest fitting in-use page, else lowest unused page.
  always_comb begin
    logic             any_used;
    logic             any_free;
    logic [IDX_W-1:0] pick_used;
    logic [IDX_W-1:0] pick_free;
    any_used  = 1'b0;
    any_free  = 1'b0;
    pick_used = '0;
    pick_free = '0;
    for (int p = PAGE_COUNT - 1; p >= 0; p--) begin
      if (fit[p]) begin
        any_used  = 1'b1;
        pick_used = IDX_W'(p);
      end
      if (!in_use_q[p]) begin
        any_free  = 1'b1;
        pick_free = IDX_W'(p);
      end
    end
    pick_d  = any_used ? pick_used : pick_free;
    new_d   = !any_used;
    found_d = (size_ext <= PAGE_LIM) && (any_used || any_free);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      pick_q  <= pick_d;
      found_q <= found_d;
      new_q   <= new_d;
    end
  end

  // Free target selection; indexes beyond the pages select nothing.
  assign idx_ext = IDXX_W'(idx_q);
  assign idx_ok  = 32'(idx_ext) < PAGE_COUNT;

  always_comb begin
    free_ok   = 1'b0;
    free_cnt  = '0;
    pick_fill = '0;
    pick_cnt  = '0;
    for (int p = 0; p < PAGE_COUNT; p++) begin
      sel_free[p] = idx_ok && (idx_ext == IDXX_W'(p));
      if (sel_free[p]) begin
        free_ok  = in_use_q[p];
        free_cnt = cnt_q[p];
      end
      if (pick_q == IDX_W'(p)) begin
        pick_fill = fill_q[p];
        pick_cnt  = cnt_q[p];
      end
    end
  end

  assign release_pg = free_ok && (free_cnt <= CNT_W'(1));

  // Allocation values; a freshly taken page starts empty.
  assign base_fill = new_q ? '0 : pick_fill;
  assign base_ext  = CMP_W'(base_fill);
  assign fill_nx   = FILL_W'(base_ext + size_ext);
  assign cnt_nx    = new_q ? CNT_W'(1) : ((pick_cnt == CNT_MAX) ? pick_cnt : pick_cnt + 1'b1);
  assign pick_ext  = PICK_W'(pick_q);

  // Saturating total arithmetic.
  assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(size_q);
  assign total_add = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
  assign total_sub = (TOTAL_W'(size_q) > total_q) ? '0 : total_q - TOTAL_W'(size_q);

  always_comb begin
    total_nx = total_q;
    unique case (op_q)
      OP_ALLOC: if (found_q) total_nx = total_add;
      OP_FREE:  if (free_ok) total_nx = total_sub;
      OP_CLEAR: total_nx = '0;
      OP_NONE:  total_nx = total_q;
      default:  total_nx = total_q;
    endcase
  end

  // Page table update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      total_q  <= '0;
      for (int p = 0; p < PAGE_COUNT; p++) begin
        fill_q[p] <= '0;
        cnt_q[p]  <= '0;
      end
    end else if (cmd_i.update) begin
      total_q <= total_nx;
      for (int p = 0; p < PAGE_COUNT; p++) begin
        unique case (op_q)
          OP_ALLOC: begin
            if (found_q && (pick_q == IDX_W'(p))) begin
              in_use_q[p] <= 1'b1;
              fill_q[p]   <= fill_nx;
              cnt_q[p]    <= cnt_nx;
            end
          end
          OP_FREE: begin
            if (free_ok && sel_free[p]) begin
              if (release_pg) begin
                in_use_q[p] <= 1'b0;
                fill_q[p]   <= '0;
                cnt_q[p]    <= '0;
              end else begin
                cnt_q[p] <= cnt_q[p] - 1'b1;
              end
            end
          end
          OP_CLEAR: begin
            in_use_q[p] <= 1'b0;
            fill_q[p]   <= '0;
            cnt_q[p]    <= '0;
          end
          OP_NONE: begin
            in_use_q[p] <= in_use_q[p];
          end
          default: begin
            in_use_q[p] <= in_use_q[p];
          end
        endcase
      end
    end
  end

  // Result fields of the current request.
  always_comb begin
    status_nx   = ST_OK;
    gpage_nx    = '0;
    goff_nx     = '0;
    released_nx = 1'b0;
    if (op_q == OP_ALLOC) begin
      if (found_q) begin
        gpage_nx = pick_ext[GPAGE_W-1:0];
        goff_nx  = base_ext[OFF_W-1:0];
      end else begin
        status_nx = ST_OOM;
      end
    end else if (op_q == OP_FREE) begin
      if (free_ok) begin
        released_nx = release_pg;
      end else begin
        status_nx = ST_INVALID;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      status_o   <= status_nx;
      gpage_o    <= gpage_nx;
      goff_o     <= goff_nx;
      released_o <= released_nx;
      total_o    <= total_nx;
    end
  end

endmodule

[design/paged_bump_allocator_refcount.sv]
// Paged bump allocator with per-page entry reference counts: one result item per request
// item. Each request passes the idle, scan and update states in turn: the idle state
// accepts and captures it, the scan state runs the page search (a parallel room check over
// all pages and a priority pick of the lowest fitting page), and the update state updates
// the page tables, loads the result and returns to idle, after which the result is offered.
// A new request is accepted while the previous result still waits, but only once the previous
// request is back in idle; the update stalls only while an untaken result occupies the output
// register. No clearing pass follows reset.
`include "assert_macros.svh"

module paged_bump_allocator_refcount #(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned PAGE_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [12:0] entry_size, [15:13] free_page_index
  input  logic [15:0] s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] granted_page, [15:3] granted_offset, [16] page_released, [32:17] total_bytes,
  // [39:33] zero
  output logic [39:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);
  import pba_pkg::*;

  pba_cmd_t            cmd;
  logic [STATUS_W-1:0] status;
  logic [GPAGE_W-1:0]  gpage;
  logic [OFF_W-1:0]    goff;
  logic                released;
  logic [TOTAL_W-1:0]  total;

  // Sequencing of one request at a time.
  pba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  // Page tables, search and result.
  pba_dp #(
    .PAGE_BYTES (PAGE_BYTES),
    .PAGE_COUNT (PAGE_COUNT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .op_i       (s_axis_tuser),
    .size_i     (s_axis_tdata[12:0]),
    .idx_i      (s_axis_tdata[15:13]),
    .status_o   (status),
    .gpage_o    (gpage),
    .goff_o     (goff),
    .released_o (released),
    .total_o    (total)
  );

  // Result item packing.
  assign m_axis_tdata = {7'd0, total, released, goff, gpage};
  assign m_axis_tuser = status;

  // An accepted item is searched in the next cycle.
  `PBA_ASSERT(a_accept_then_scan, (s_axis_tvalid && s_axis_tready) |=> cmd.scan, "no scan")
  // The update never overwrites a result that is still waiting.
  `PBA_ASSERT(a_no_overwrite, cmd.update |-> (!m_axis_tvalid || m_axis_tready), "overwrite")
  // Every update presents a result in the next cycle.
  `PBA_ASSERT(a_update_then_valid, cmd.update |=> m_axis_tvalid, "update without result")
  // No item is taken while one is in the search.
  `PBA_ASSERT(a_busy_not_ready, cmd.scan |-> !s_axis_tready, "ready while searching")
  // Reset leaves no result pending.
  `PBA_ASSERT_ALWAYS(a_reset_clears, !rst_ni |=> !m_axis_tvalid, "result valid after reset")

endmodule

[test/tb_top.sv]
// Self-checking testbench for the paged bump allocator with per-page entry counts.
`timescale 1ns / 100ps

module tb_top;
  import pba_pkg::*;

  localparam int unsigned PAGE_BYTES   = 4096;
  localparam int unsigned PAGE_COUNT   = 8;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;

  // One expected result item.
  typedef struct {
    status_e     status;
    logic [2:0]  page;
    logic [12:0] offset;
    logic        released;
    logic [15:0] total;
  } grant_t;

  // Shadow of the page tables that predicts each result and checks it on arrival.
  class alloc_scoreboard;
    bit          in_use [PAGE_COUNT];
    bit [12:0]   fill   [PAGE_COUNT];
    bit [15:0]   count  [PAGE_COUNT];
    bit [15:0]   held;
    grant_t      grants_due [$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned n_granted;
    int unsigned n_oom;
    int unsigned n_invalid;
    int unsigned n_released;
    int unsigned n_clears;

    function void drop_page(int unsigned p);
      in_use[p] = 1'b0;
      fill[p]   = '0;
      count[p]  = '0;
    endfunction

    // Apply one accepted request to the shadow tables and queue its result.
    function void note_request(op_e op, logic [12:0] size, logic [2:0] idx);
      grant_t g;
      bit     found;
      int     pick;
      int     sum;
      g.status   = ST_OK;
      g.page     = '0;
      g.offset   = '0;
      g.released = 1'b0;
      found      = 1'b0;
      pick       = 0;
      requests++;
      case (op)
        OP_ALLOC: begin
          if (size <= PAGE_BYTES) begin
            // Lowest in-use page with room first, then the lowest unused page.
            for (int p = 0; p < PAGE_COUNT && !found; p++) begin
              if (in_use[p] && (int'(PAGE_BYTES) - int'(fill[p]) >= int'(size))) begin
                pick  = p;
                found = 1'b1;
              end
            end
            for (int p = 0; p < PAGE_COUNT && !found; p++) begin
              if (!in_use[p]) begin
                drop_page(p);
                in_use[p] = 1'b1;
                pick      = p;
                found     = 1'b1;
              end
            end
          end
          if (found) begin
            g.page     = pick[2:0];
            g.offset   = fill[pick];
            fill[pick] = fill[pick] + size;
            if (count[pick] != 16'hFFFF) count[pick]++;
            sum  = int'(held) + int'(size);
            held = (sum > 65535) ? 16'hFFFF : sum[15:0];
            n_granted++;
          end else begin
            g.status = ST_OOM;
            n_oom++;
          end
        end
        OP_FREE: begin
          if (!in_use[idx]) begin
            g.status = ST_INVALID;
            n_invalid++;
          end else begin
            held = (size > held) ? '0 : held - size;
            if (count[idx] <= 1) begin
              drop_page(idx);
              g.released = 1'b1;
              n_released++;
            end else begin
              count[idx]--;
            end
          end
        end
        OP_CLEAR: begin
          for (int p = 0; p < PAGE_COUNT; p++) drop_page(p);
          held = '0;
          n_clears++;
        end
        default: begin
        end
      endcase
      g.total = held;
      grants_due.push_back(g);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    // Compare one accepted result item with the oldest expectation.
    function void check_result(logic [1:0] status, logic [2:0] page, logic [12:0] offset,
                               logic released, logic [15:0] total, logic [6:0] pad);
      grant_t g;
      if (grants_due.size() == 0) begin
        report($sformatf("result with none expected: status %0d page %0d total %0d",
                         status, page, total));
        return;
      end
      g = grants_due.pop_front();
      if (status !== g.status)
        report($sformatf("status exp %0d got %0d", g.status, status));
      if (page !== g.page)
        report($sformatf("granted_page exp %0d got %0d", g.page, page));
      if (offset !== g.offset)
        report($sformatf("granted_offset exp %0d got %0d", g.offset, offset));
      if (released !== g.released)
        report($sformatf("page_released exp %0d got %0d", g.released, released));
      if (total !== g.total)
        report($sformatf("total_bytes exp %0d got %0d", g.total, total));
      if (pad !== 7'd0)
        report($sformatf("unused result bits exp 0 got %0h", pad));
    endfunction

    function int unsigned pending();
      return grants_due.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  alloc_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned rdy_mode    = 0;
  int unsigned rdy_left    = 0;
  int unsigned stall_left  = 0;

  paged_bump_allocator_refcount #(
    .PAGE_BYTES(PAGE_BYTES),
    .PAGE_COUNT(PAGE_COUNT)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("FAIL");
      $finish;
    end
  end

  // Result side: check accepted items and stall on a changing pattern.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[15:3], m_axis_tdata[16],
                      m_axis_tdata[32:17], m_axis_tdata[39:33]);
    end
    if (rdy_left == 0) begin
      rdy_mode <= $urandom_range(0, 3);
      rdy_left <= $urandom_range(20, 120);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    case (rdy_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (cycle_count % 4 == 0);
      default: begin
        if (stall_left != 0) begin
          m_axis_tready <= 1'b0;
          stall_left    <= stall_left - 1;
        end else begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 12);
        end
      end
    endcase
  end

  // Offer one request item and hold it until accepted; valid stays high afterwards.
  task automatic send_request(input op_e op, input logic [12:0] size, input logic [2:0] idx);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {idx, size};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(op, size, idx);
  endtask

  function automatic logic [12:0] pick_alloc_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 13'd0;
    if (r < 15) return 13'd4096;
    if (r < 25) return 13'($urandom_range(4097, 8191));
    if (r < 50) return 13'($urandom_range(1, 256));
    if (r < 80) return 13'($urandom_range(257, 2048));
    return 13'($urandom_range(2049, 4095));
  endfunction

  function automatic logic [12:0] pick_free_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 13'($urandom_range(0, 512));
    if (r < 80) return 13'($urandom_range(0, 4096));
    if (r < 90) return 13'($urandom_range(7000, 8191));
    return 13'($urandom);
  endfunction

  // Free index: mostly a page in use, otherwise any page.
  function automatic logic [2:0] pick_free_page();
    int unsigned live [$];
    for (int p = 0; p < PAGE_COUNT; p++) if (sb.in_use[p]) live.push_back(p);
    if (live.size() != 0 && $urandom_range(0, 99) < 80)
      return 3'(live[$urandom_range(0, live.size() - 1)]);
    return 3'($urandom);
  endfunction

  // Random traffic in bursts with gaps between them.
  task automatic run_random();
    int unsigned counted;
    int unsigned burst;
    int unsigned r;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst; i++) begin
        r = $urandom_range(0, 99);
        if (r < 52) begin
          send_request(OP_ALLOC, pick_alloc_size(), 3'($urandom));
          counted++;
        end else if (r < 94) begin
          send_request(OP_FREE, pick_free_size(), pick_free_page());
          counted++;
        end else if (r < 96) begin
          send_request(OP_CLEAR, 13'($urandom), 3'($urandom));
          counted++;
        end else begin
          send_request(OP_NONE, 13'($urandom), 3'($urandom));
        end
      end
      // Roughly one burst in three runs straight into the next one.
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty tables, page limits, oversize and no-room cases.
    send_request(OP_FREE,  13'd0,    3'd0);   // free of an unused page
    send_request(OP_ALLOC, 13'd0,    3'd0);   // zero size opens page 0
    send_request(OP_ALLOC, 13'd4096, 3'd7);   // exactly fills page 0
    send_request(OP_ALLOC, 13'd4097, 3'd0);   // just above a page
    send_request(OP_ALLOC, 13'd8191, 3'd0);   // largest size field
    send_request(OP_ALLOC, 13'd1,    3'd0);   // opens page 1
    send_request(OP_ALLOC, 13'd0,    3'd0);   // zero size fits the full page 0
    send_request(OP_NONE,  13'd8191, 3'd7);   // unused code changes nothing
    send_request(OP_FREE,  13'd8191, 3'd0);   // free above the total saturates at zero
    send_request(OP_FREE,  13'd0,    3'd0);
    send_request(OP_FREE,  13'd0,    3'd0);   // last entry releases page 0
    send_request(OP_FREE,  13'd5,    3'd7);   // highest index, unused
    for (int i = 0; i < 7; i++) send_request(OP_ALLOC, 13'd4096, 3'd0);
    send_request(OP_ALLOC, 13'd4095, 3'd0);   // fills page 1 to the brim
    send_request(OP_ALLOC, 13'd1,    3'd0);   // no room anywhere
    send_request(OP_ALLOC, 13'd0,    3'd0);   // zero size still fits
    send_request(OP_CLEAR, 13'd8191, 3'd7);
    send_request(OP_FREE,  13'd1,    3'd3);   // page gone after the clear
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    run_random();
    s_axis_tvalid <= 1'b0;

    // Drain the outstanding results, then allow for stray late items.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests in %0d cycles: %0d granted, %0d out of memory,",
             sb.requests, cycle_count, sb.n_granted, sb.n_oom);
    $display("%0d invalid frees, %0d page releases, %0d clears; %0d mismatches.",
             sb.n_invalid, sb.n_released, sb.n_clears, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
